// File: design/link_keepalive_monitor_assert.svh
// Assertion macros for the keepalive monitor.
// Uses the clk and rst names of the including module.
`ifndef LINK_KEEPALIVE_MONITOR_ASSERT_SVH
`define LINK_KEEPALIVE_MONITOR_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define LKM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define LKM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lkm_pkg.sv
// Shared constants for the keepalive monitor: codes, register indexes, resets.
// No dependencies.
package lkm_pkg;

  localparam int TIME_WIDTH_DEF  = 48;
  localparam int CFG_WIDTH       = 32;
  localparam int CFG_INDEX_WIDTH = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PING_INTERVAL  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REPLY_TIMEOUT  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAIL_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WD_INTERVAL    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_POWEROFF       = 3'd4;

  // Event codes.
  localparam logic [1:0] OP_START     = 2'd0;
  localparam logic [1:0] OP_TICK      = 2'd1;
  localparam logic [1:0] OP_REPLY     = 2'd2;
  localparam logic [1:0] OP_RECV_ERR  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_CONTINUE  = 2'd0;
  localparam logic [1:0] ST_STOP      = 2'd1;
  localparam logic [1:0] ST_ERROR     = 2'd2;

  // Watchdog edge codes.
  localparam logic [1:0] WD_EDGE_NONE = 2'd0;
  localparam logic [1:0] WD_EDGE_FAIL = 2'd1;
  localparam logic [1:0] WD_EDGE_OK   = 2'd2;

  // Register reset values.
  localparam logic [31:0] PING_INTERVAL_RST  = 32'd1000;
  localparam logic [31:0] REPLY_TIMEOUT_RST  = 32'd1000;
  localparam logic [7:0]  FAIL_THRESHOLD_RST = 8'd3;
  localparam logic [31:0] WD_INTERVAL_RST    = 32'd0;

  localparam logic [7:0]  FAIL_MAX = 8'hFF;
  localparam logic signed [31:0] WAKE_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WAKE_NONE = -32'sd1;

endpackage

// File: design/link_keepalive_monitor.sv
// Keepalive ping / reply timeout supervisor with watchdog kick scheduling.
// Path: an accepted item is held in the input register, then its result is
// registered in the result register, where it waits for the output handshake.
// Throughput: one item per cycle; a stalled result holds the input register full.
// Reset (rst, synchronous, active high): config to defaults, deadlines disarmed
// except the ping deadline (zero), counters and flags cleared, both stages empty.
module link_keepalive_monitor
  import lkm_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write port
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  // event channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 operation,
  input  logic [TIME_WIDTH-1:0]      now_ms,
  input  logic                       send_ok,
  input  logic [15:0]                ping_sequence,
  input  logic                       watchdog_sent_ok,
  input  logic                       shutdown_ok,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic                       ping_request,
  output logic                       watchdog_kick,
  output logic [1:0]                 watchdog_edge,
  output logic                       ping_timed_out,
  output logic                       ping_succeeded,
  output logic [7:0]                 failures_in_row,
  output logic                       shutdown_request,
  output logic [15:0]                reply_sequence,
  output logic [TIME_WIDTH-1:0]      reply_send_time,
  output logic signed [31:0]         wake_in_ms
);

  `include "link_keepalive_monitor_assert.svh"

  // All ones in a deadline means disarmed.
  localparam logic [TIME_WIDTH-1:0] TMASK = '1;

  // ---------------------------------------------------------------------------
  // Time helpers
  // ---------------------------------------------------------------------------

  // Add a 32-bit interval to a deadline; a carry out saturates to disarmed.
  function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
                                                    input logic [31:0] b);
    logic [TIME_WIDTH:0] s;
    s = {1'b0, a} + {{(TIME_WIDTH + 1 - 32){1'b0}}, b};
    return s[TIME_WIDTH] ? TMASK : s[TIME_WIDTH-1:0];
  endfunction

  function automatic logic elapsed(input logic [TIME_WIDTH-1:0] t,
                                   input logic [TIME_WIDTH-1:0] now);
    return (t != TMASK) && (now >= t);
  endfunction

  // Step a periodic deadline from its old value to keep phase, but never
  // leave it behind now.
  function automatic logic [TIME_WIDTH-1:0] step_timer(input logic [TIME_WIDTH-1:0] t,
                                                       input logic [31:0] interval,
                                                       input logic [TIME_WIDTH-1:0] now);
    logic [TIME_WIDTH-1:0] base;
    logic [TIME_WIDTH-1:0] nxt;
    base = (t != TMASK) ? t : now;
    nxt  = sat_add(base, interval);
    if (nxt < now) begin
      nxt = sat_add(now, interval);
    end
    return nxt;
  endfunction

  // Milliseconds until a deadline: -1 when disarmed, clamped to the int range.
  function automatic logic signed [31:0] time_left(input logic [TIME_WIDTH-1:0] t,
                                                   input logic [TIME_WIDTH-1:0] now);
    logic [TIME_WIDTH-1:0] diff;
    diff = t - now;
    if (t == TMASK) begin
      return WAKE_NONE;
    end else if (t <= now) begin
      return 32'sd0;
    end else if (diff > {{(TIME_WIDTH - 31){1'b0}}, 31'h7FFF_FFFF}) begin
      return WAKE_MAX;
    end else begin
      return $signed(diff[31:0]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] ping_interval;
  logic [31:0] reply_timeout;
  logic [7:0]  fail_limit;
  logic [31:0] wd_interval;
  logic        poweroff_enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      ping_interval    <= PING_INTERVAL_RST;
      reply_timeout    <= REPLY_TIMEOUT_RST;
      fail_limit       <= FAIL_THRESHOLD_RST;
      wd_interval      <= WD_INTERVAL_RST;
      poweroff_enabled <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PING_INTERVAL:  ping_interval    <= cfg_data;
        REG_REPLY_TIMEOUT:  reply_timeout    <= cfg_data;
        REG_FAIL_THRESHOLD: fail_limit       <= cfg_data[7:0];
        REG_WD_INTERVAL:    wd_interval      <= cfg_data;
        REG_POWEROFF:       poweroff_enabled <= cfg_data[0];
        default: ; // writes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds the result register through the event
  // logic. The input stage advances whenever the result register is empty or
  // is being drained, so one item moves through per cycle.
  // ---------------------------------------------------------------------------
  logic                  s1_valid;
  logic [1:0]            op_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic                  send_ok_q;
  logic [15:0]           seq_q;
  logic                  wd_ok_q;
  logic                  sd_ok_q;

  logic advance;   // result register can take the item held in stage 1
  logic commit;    // stage 1 item is processed this cycle

  assign advance  = !out_valid || out_ready;
  assign commit   = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Payload of stage 1 needs no reset; hold it while stalled.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_q      <= operation;
      now_q     <= now_ms;
      send_ok_q <= send_ok;
      seq_q     <= ping_sequence;
      wd_ok_q   <= watchdog_sent_ok;
      sd_ok_q   <= shutdown_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor state
  // ---------------------------------------------------------------------------
  logic [TIME_WIDTH-1:0] ping_due;
  logic [TIME_WIDTH-1:0] reply_due;
  logic [TIME_WIDTH-1:0] wd_due;
  logic [TIME_WIDTH-1:0] send_time;
  logic [15:0]           await_seq;
  logic [7:0]            fail_count;
  logic                  wd_failed;

  logic [TIME_WIDTH-1:0] ping_due_next;
  logic [TIME_WIDTH-1:0] reply_due_next;
  logic [TIME_WIDTH-1:0] wd_due_next;
  logic [TIME_WIDTH-1:0] send_time_next;
  logic [15:0]           await_seq_next;
  logic [7:0]            fail_count_next;
  logic                  wd_failed_next;

  // Per-event result fields before the result register.
  logic [1:0]         status_next;
  logic               ping_request_next;
  logic               kick_next;
  logic [1:0]         wd_edge_next;
  logic               timed_out_next;
  logic               succeeded_next;
  logic               shutdown_req_next;
  logic signed [31:0] wake_next;
  logic signed [31:0] wake_main;
  logic signed [31:0] wake_wd;

  always_comb begin
    ping_due_next     = ping_due;
    reply_due_next    = reply_due;
    wd_due_next       = wd_due;
    send_time_next    = send_time;
    await_seq_next    = await_seq;
    fail_count_next   = fail_count;
    wd_failed_next    = wd_failed;
    status_next       = ST_CONTINUE;
    ping_request_next = 1'b0;
    kick_next         = 1'b0;
    wd_edge_next      = WD_EDGE_NONE;
    timed_out_next    = 1'b0;
    succeeded_next    = 1'b0;
    shutdown_req_next = 1'b0;

    case (op_q)
      OP_START: begin
        // Restart: ping right away, no reply pending, watchdog from now.
        ping_due_next   = now_q;
        reply_due_next  = TMASK;
        wd_due_next     = (wd_interval != 32'd0) ? sat_add(now_q, wd_interval) : TMASK;
        send_time_next  = '0;
        await_seq_next  = '0;
        fail_count_next = '0;
        wd_failed_next  = 1'b0;
      end

      OP_TICK: begin
        // Watchdog first: kick, reschedule, flag fail/recover edges.
        if (elapsed(wd_due, now_q)) begin
          kick_next   = 1'b1;
          wd_due_next = step_timer(wd_due, wd_interval, now_q);
          if (!wd_ok_q && !wd_failed) begin
            wd_edge_next = WD_EDGE_FAIL;
          end else if (wd_ok_q && wd_failed) begin
            wd_edge_next = WD_EDGE_OK;
          end
          wd_failed_next = !wd_ok_q;
        end

        // Reply deadline missed: count the failure, drop the in-flight ping,
        // request shutdown once the threshold is reached.
        if (elapsed(reply_due, now_q)) begin
          timed_out_next  = 1'b1;
          fail_count_next = (fail_count != FAIL_MAX) ? fail_count + 8'd1 : fail_count;
          reply_due_next  = TMASK;
          send_time_next  = '0;
          await_seq_next  = '0;
          if (fail_count_next >= fail_limit) begin
            shutdown_req_next = 1'b1;
            if (!poweroff_enabled || sd_ok_q) begin
              status_next = ST_STOP;
            end
          end
        end

        // Ping scheduler: only with nothing in flight and not stopping.
        if ((status_next == ST_CONTINUE) && (reply_due_next == TMASK) &&
            elapsed(ping_due, now_q)) begin
          ping_request_next = 1'b1;
          if (!send_ok_q) begin
            // Failed send: report error, keep the ping deadline where it is.
            status_next = ST_ERROR;
          end else begin
            reply_due_next = sat_add(now_q, reply_timeout);
            send_time_next = now_q;
            await_seq_next = seq_q;
            ping_due_next  = step_timer(ping_due, ping_interval, now_q);
          end
        end
      end

      OP_REPLY: begin
        // A reply only counts while a ping is in flight.
        if (reply_due != TMASK) begin
          succeeded_next  = 1'b1;
          fail_count_next = '0;
          reply_due_next  = TMASK;
          send_time_next  = '0;
          await_seq_next  = '0;
        end
      end

      OP_RECV_ERR: begin
        reply_due_next = TMASK;
        send_time_next = '0;
        await_seq_next = '0;
        status_next    = ST_ERROR;
      end

      default: ;
    endcase

    // Next wake: reply deadline when in flight, else next ping; then the
    // earlier of that and the watchdog, ignoring disarmed ones.
    wake_main = (reply_due_next != TMASK) ? time_left(reply_due_next, now_q)
                                          : time_left(ping_due_next, now_q);
    wake_wd   = time_left(wd_due_next, now_q);
    if (wake_wd < 0) begin
      wake_next = wake_main;
    end else if ((wake_main < 0) || (wake_wd < wake_main)) begin
      wake_next = wake_wd;
    end else begin
      wake_next = wake_main;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ping_due   <= '0;
      reply_due  <= TMASK;
      wd_due     <= TMASK;
      send_time  <= '0;
      await_seq  <= '0;
      fail_count <= '0;
      wd_failed  <= 1'b0;
    end else if (commit) begin
      ping_due   <= ping_due_next;
      reply_due  <= reply_due_next;
      wd_due     <= wd_due_next;
      send_time  <= send_time_next;
      await_seq  <= await_seq_next;
      fail_count <= fail_count_next;
      wd_failed  <= wd_failed_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status           <= status_next;
      ping_request     <= ping_request_next;
      watchdog_kick    <= kick_next;
      watchdog_edge    <= wd_edge_next;
      ping_timed_out   <= timed_out_next;
      ping_succeeded   <= succeeded_next;
      failures_in_row  <= fail_count_next;
      shutdown_request <= shutdown_req_next;
      reply_sequence   <= await_seq_next;
      reply_send_time  <= send_time_next;
      wake_in_ms       <= wake_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `LKM_ASSERT_SAME(a_shutdown_on_timeout, out_valid && shutdown_request, ping_timed_out,
                   "shutdown request without a reply timeout")
  `LKM_ASSERT_SAME(a_no_ping_on_stop, out_valid && ping_request, status != ST_STOP,
                   "ping issued on a stopping event")
  `LKM_ASSERT_SAME(a_success_clears_count, out_valid && ping_succeeded,
                   failures_in_row == 8'd0, "failure count kept after a matched reply")
  `LKM_ASSERT_NEXT(a_stage1_holds, s1_valid && !advance, s1_valid,
                   "stalled item dropped from the input register")

endmodule
